// File: rtl/hdmlc_pkg.sv
// Shared types, constants and the hash mixing step for the hashed lookup cache.
package hdmlc_pkg;

    localparam int SLOT_COUNT_DEF = 2048;

    localparam logic [63:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam logic       FUNC_LOOKUP = 1'b0;
    localparam logic       FUNC_FILL   = 1'b1;

    localparam logic [2:0] STEP_ID_LOW  = 3'd0;
    localparam logic [2:0] STEP_ID_HIGH = 3'd1;
    localparam logic [2:0] STEP_FLAGS   = 3'd4;
    localparam logic [2:0] STEP_LAST    = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] ident;
        logic [31:0] flags;
        logic [31:0] value;
    } entry_t;

    // One FNV-1a round: xor the word in, multiply by 0x100000001B3 (mod 2^64).
    // The prime is 2^40 + 0x1B3, so the product is a short shift-add.
    function automatic logic [63:0] hdmlc_mix(input logic [63:0] h, input logic [31:0] w);
        logic [63:0] x;
        begin
            x = h ^ {32'd0, w};
            return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
        end
    endfunction

endpackage

// File: rtl/hashed_direct_mapped_lookup_cache_unit.sv
// Direct-mapped lookup cache with an FNV-1a slot index, one table memory.
// Flow: an accepted beat is hashed in the shared hash round unit, then the table is read,
// then the compare/write registers the result beat.
// One item in flight: a new beat is taken only in the idle state after the last response;
// the hash unit, the single-port table read and a stalled result output hold the flow.
// Reset: a clearing pass zeroes every table slot while s_axis_tready is low.
module hashed_direct_mapped_lookup_cache_unit #(
    parameter int SLOT_COUNT = hdmlc_pkg::SLOT_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // id_low, id_high, flag_word, fill_value
    input  logic [0:0]   s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // hit_value
    output logic [1:0]   m_axis_tuser   // hit, stored
);
    import hdmlc_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(SLOT_COUNT - 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [2:0]         step_reg, step_next;
    logic [63:0]        hash_reg, hash_next;

    logic               func_reg;
    logic [63:0]        id_reg;
    logic [31:0]        flag_reg;
    logic [31:0]        fill_reg;

    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic [31:0]        out_value_reg, out_value_next;
    logic               out_stored_reg, out_stored_next;

    entry_t             mem [SLOT_COUNT];
    entry_t             rd_data_reg;
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic [IDX_W-1:0]   slot_idx;
    logic [31:0]        hash_word;
    logic               accept;
    logic               out_free;
    logic               key_match;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_idx  = hash_reg[IDX_W-1:0] & IDX_MASK;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign key_match = rd_data_reg.valid && (rd_data_reg.ident == id_reg)
                       && (rd_data_reg.flags == flag_reg);

    always_comb
    begin
        case (step_reg)
            STEP_ID_LOW:  hash_word = id_reg[31:0];
            STEP_ID_HIGH: hash_word = id_reg[63:32];
            STEP_FLAGS:   hash_word = flag_reg;
            default:      hash_word = 32'd0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        step_next       = step_reg;
        hash_next       = hash_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_hit_next    = out_hit_reg;
        out_value_next  = out_value_reg;
        out_stored_next = out_stored_reg;
        s_axis_tready   = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = slot_idx;
        wr_data         = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_MASK)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_HASH;
                    step_next  = '0;
                    hash_next  = HASH_BASIS;
                end
            end
            ST_HASH:
            begin
                hash_next = hdmlc_mix(hash_reg, hash_word);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (func_reg == FUNC_FILL)
                    begin
                        out_hit_next    = 1'b0;
                        out_value_next  = 32'd0;
                        out_stored_next = (fill_reg != 32'd0);
                        wr_en           = (fill_reg != 32'd0);
                        wr_data.valid   = 1'b1;
                        wr_data.ident   = id_reg;
                        wr_data.flags   = flag_reg;
                        wr_data.value   = fill_reg;
                    end
                    else
                    begin
                        out_hit_next    = key_match;
                        out_value_next  = key_match ? rd_data_reg.value : 32'd0;
                        out_stored_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg       <= hash_next;
        out_hit_reg    <= out_hit_next;
        out_value_reg  <= out_value_next;
        out_stored_reg <= out_stored_next;
        if (accept)
        begin
            func_reg <= s_axis_tuser[0];
            id_reg   <= s_axis_tdata[63:0];
            flag_reg <= s_axis_tdata[95:64];
            fill_reg <= s_axis_tdata[127:96];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[slot_idx];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = {out_stored_reg, out_hit_reg};

    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_CLEAR || state_reg == ST_RESP))
        else $error("table write outside clear or response");

    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_HASH && step_reg == 3'd0 && hash_reg == HASH_BASIS))
        else $error("accepted beat did not start hashing");

    a_hit_stored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_stored_reg))
        else $error("result flags both hit and stored");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> (out_value_reg == 32'd0))
        else $error("nonzero value on miss");

    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RESP))
        else $error("result beat raised outside response");

endmodule

// File: test/cache_result_checker.sv
// Result checker for the hashed lookup cache: slot-table predictor and in-order compare.
package cache_tb_pkg;

    localparam int unsigned TB_SLOTS = hdmlc_pkg::SLOT_COUNT_DEF;
    localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME  = 64'h0000_0100_0000_01B3;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_value;
        logic        stored;
    } lookup_result_t;

    function automatic int unsigned slot_index(input logic [31:0] lo, input logic [31:0] hi,
                                               input logic [31:0] fl);
        logic [63:0] h;
        logic [31:0] words [5];
        begin
            words[0] = lo;
            words[1] = hi;
            words[2] = 32'd0;
            words[3] = 32'd0;
            words[4] = fl;
            h = FNV_OFFSET;
            for (int i = 0; i < 5; i++)
            begin
                h = (h ^ {32'd0, words[i]}) * FNV_PRIME;
            end
            return int'(h[31:0] & (TB_SLOTS - 1));
        end
    endfunction

endpackage

module cache_result_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // id_low, id_high, flag_word, fill_value
    input  logic [0:0]   s_axis_tuser,  // func
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,  // hit_value
    input  logic [1:0]   m_axis_tuser,  // hit, stored
    output int           fail_count,
    output int           pending,
    output int           n_lookup,
    output int           n_hit,
    output int           n_fill,
    output int           n_stored
);
    import cache_tb_pkg::*;

    logic        cached_valid [TB_SLOTS];
    logic [63:0] cached_id    [TB_SLOTS];
    logic [31:0] cached_flags [TB_SLOTS];
    logic [31:0] cached_value [TB_SLOTS];

    lookup_result_t expected_q [$];

    always @(posedge clk)
    begin : monitor
        lookup_result_t want;
        lookup_result_t got;
        int unsigned    idx;
        logic [31:0]    lo;
        logic [31:0]    hi;
        logic [31:0]    fl;
        logic [31:0]    fv;
        if (!rst_n)
        begin
            for (int i = 0; i < TB_SLOTS; i++)
            begin
                cached_valid[i] = 1'b0;
            end
            expected_q.delete();
            fail_count = 0;
            n_lookup   = 0;
            n_hit      = 0;
            n_fill     = 0;
            n_stored   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hit       = m_axis_tuser[0];
                got.stored    = m_axis_tuser[1];
                got.hit_value = m_axis_tdata;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: hit=%0d value=%h stored=%0d",
                             $time, got.hit, got.hit_value, got.stored);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $display("%0t: hit mismatch: expected %0d actual %0d",
                                 $time, want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.hit_value !== want.hit_value)
                    begin
                        $display("%0t: hit_value mismatch: expected %h actual %h",
                                 $time, want.hit_value, got.hit_value);
                        fail_count++;
                    end
                    if (got.stored !== want.stored)
                    begin
                        $display("%0t: stored mismatch: expected %0d actual %0d",
                                 $time, want.stored, got.stored);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                lo   = s_axis_tdata[31:0];
                hi   = s_axis_tdata[63:32];
                fl   = s_axis_tdata[95:64];
                fv   = s_axis_tdata[127:96];
                idx  = slot_index(lo, hi, fl);
                want = '0;
                if (s_axis_tuser[0] == hdmlc_pkg::FUNC_LOOKUP)
                begin
                    n_lookup++;
                    if (cached_valid[idx] && cached_id[idx] == {hi, lo} && cached_flags[idx] == fl)
                    begin
                        want.hit       = 1'b1;
                        want.hit_value = cached_value[idx];
                        n_hit++;
                    end
                end
                else
                begin
                    n_fill++;
                    if (fv != 32'd0)
                    begin
                        cached_valid[idx] = 1'b1;
                        cached_id[idx]    = {hi, lo};
                        cached_flags[idx] = fl;
                        cached_value[idx] = fv;
                        want.stored       = 1'b1;
                        n_stored++;
                    end
                end
                expected_q.push_back(want);
            end
        end
        pending <= expected_q.size();
    end

endmodule

// File: test/tb_top.sv
// Testbench top for the hashed lookup cache: stimulus, handshake pacing and verdict.
module tb_top;
    import cache_tb_pkg::*;

    localparam int POOL       = 24;
    localparam int RAND_BEATS = 720;
    localparam int IDLE_LIMIT = 12000;
    localparam logic [31:0] ONES = 32'hFFFF_FFFF;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;  // id_low, id_high, flag_word, fill_value
    logic [0:0]   s_axis_tuser;  // func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;  // hit_value
    logic [1:0]   m_axis_tuser;  // hit, stored

    int fail_count;
    int pending;
    int n_lookup;
    int n_hit;
    int n_fill;
    int n_stored;

    int beats_sent;
    int burst_left;
    int idle_cycles = 0;
    int ready_mode  = 0;
    int ready_left  = 0;
    int ready_cyc   = 0;
    int n_alias;

    logic [31:0] key_lo [POOL];
    logic [31:0] key_hi [POOL];
    logic [31:0] key_fl [POOL];

    always #5 clk = ~clk;

    hashed_direct_mapped_lookup_cache_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cache_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .n_lookup      (n_lookup),
        .n_hit         (n_hit),
        .n_fill        (n_fill),
        .n_stored      (n_stored)
    );

    // receiver backpressure, pattern changes after a randomly chosen run length
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(16, 96);
        end
        ready_left--;
        ready_cyc++;
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= (ready_cyc % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("hashed_direct_mapped_lookup_cache_unit verification failed");
            $finish;
        end
    end

    task automatic send(input logic func, input logic [31:0] lo, input logic [31:0] hi,
                        input logic [31:0] fl, input logic [31:0] fv);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= func;
            s_axis_tdata  <= {fv, fl, hi, lo};
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
            burst_left--;
            beats_sent++;
        end
    endtask

    task automatic drain();
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
        end
    endtask

    // random key landing in the same slot as the given one
    task automatic find_alias(input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] fl,
                              output logic [31:0] alo, output logic [31:0] ahi,
                              output logic [31:0] afl);
        int unsigned target;
        begin
            target = slot_index(lo, hi, fl);
            do
            begin
                alo = $urandom;
                ahi = $urandom;
                afl = ($urandom_range(0, 1) == 0) ? fl : $urandom;
            end
            while (slot_index(alo, ahi, afl) != target || {alo, ahi, afl} == {lo, hi, fl});
            n_alias++;
        end
    endtask

    function automatic logic [31:0] rand_word();
        int pick;
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                return 32'd0;
            if (pick == 1)
                return ONES;
            return $urandom;
        end
    endfunction

    function automatic logic [31:0] nonzero_word();
        logic [31:0] v;
        begin
            v = rand_word();
            return (v == 32'd0) ? 32'd1 : v;
        end
    endfunction

    initial
    begin : stimulus
        logic [31:0] alo;
        logic [31:0] ahi;
        logic [31:0] afl;
        logic [31:0] fv;
        int          mode;
        int          k;
        bit          paused;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= hdmlc_pkg::FUNC_LOOKUP;
        rst_n         <= 1'b0;
        beats_sent  = 0;
        burst_left  = 0;
        n_alias     = 0;
        paused      = 1'b0;
        for (int i = 0; i < POOL; i++)
        begin
            key_lo[i] = rand_word();
            key_hi[i] = rand_word();
            key_fl[i] = rand_word();
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, zero fill, extremes, partial key match, slot aliasing
        send(hdmlc_pkg::FUNC_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0);
        send(hdmlc_pkg::FUNC_FILL,   32'd0, 32'd0, 32'd0, 32'd0);
        send(hdmlc_pkg::FUNC_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0);
        send(hdmlc_pkg::FUNC_FILL,   32'd0, 32'd0, 32'd0, ONES);
        send(hdmlc_pkg::FUNC_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0);
        send(hdmlc_pkg::FUNC_LOOKUP, 32'd0, 32'd0, 32'd1, ONES);
        send(hdmlc_pkg::FUNC_LOOKUP, 32'd0, 32'd1, 32'd0, 32'd0);
        send(hdmlc_pkg::FUNC_LOOKUP, 32'd1, 32'd0, 32'd0, 32'd0);
        send(hdmlc_pkg::FUNC_LOOKUP, ONES, ONES, ONES, 32'd0);
        send(hdmlc_pkg::FUNC_FILL,   ONES, ONES, ONES, 32'd1);
        send(hdmlc_pkg::FUNC_FILL,   ONES, ONES, ONES, 32'd0);
        send(hdmlc_pkg::FUNC_LOOKUP, ONES, ONES, ONES, ONES);
        find_alias(ONES, ONES, ONES, alo, ahi, afl);
        send(hdmlc_pkg::FUNC_LOOKUP, alo, ahi, afl, 32'd0);
        send(hdmlc_pkg::FUNC_FILL,   alo, ahi, afl, 32'h5A5A_A5A5);
        send(hdmlc_pkg::FUNC_LOOKUP, alo, ahi, afl, 32'd0);
        send(hdmlc_pkg::FUNC_LOOKUP, ONES, ONES, ONES, 32'd0);
        send(hdmlc_pkg::FUNC_FILL,   ONES, ONES, ONES, 32'h8000_0000);
        send(hdmlc_pkg::FUNC_LOOKUP, ONES, ONES, ONES, 32'd0);
        send(hdmlc_pkg::FUNC_LOOKUP, alo, ahi, afl, 32'd0);

        while (beats_sent < RAND_BEATS)
        begin
            if (!paused && beats_sent >= RAND_BEATS / 2)
            begin
                drain();
                paused = 1'b1;
            end
            mode = $urandom_range(0, 99);
            k    = $urandom_range(0, POOL - 1);
            if (mode < 15)
            begin
                key_lo[k] = rand_word();
                key_hi[k] = rand_word();
                key_fl[k] = rand_word();
            end
            if (mode < 55)
            begin
                // lookup, fill, retry the lookup
                fv = ($urandom_range(0, 4) == 0) ? 32'd0 : nonzero_word();
                send(hdmlc_pkg::FUNC_LOOKUP, key_lo[k], key_hi[k], key_fl[k], rand_word());
                send(hdmlc_pkg::FUNC_FILL,   key_lo[k], key_hi[k], key_fl[k], fv);
                send(hdmlc_pkg::FUNC_LOOKUP, key_lo[k], key_hi[k], key_fl[k], rand_word());
            end
            else if (mode < 75)
            begin
                send(hdmlc_pkg::FUNC_LOOKUP, key_lo[k], key_hi[k], key_fl[k], rand_word());
            end
            else if (mode < 88)
            begin
                find_alias(key_lo[k], key_hi[k], key_fl[k], alo, ahi, afl);
                send(hdmlc_pkg::FUNC_FILL,   alo, ahi, afl, nonzero_word());
                send(hdmlc_pkg::FUNC_LOOKUP, alo, ahi, afl, rand_word());
                send(hdmlc_pkg::FUNC_LOOKUP, key_lo[k], key_hi[k], key_fl[k], rand_word());
                key_lo[k] = alo;
                key_hi[k] = ahi;
                key_fl[k] = afl;
            end
            else
            begin
                send(($urandom_range(0, 1) == 0) ? hdmlc_pkg::FUNC_LOOKUP : hdmlc_pkg::FUNC_FILL,
                     rand_word(), rand_word(), rand_word(), rand_word());
            end
        end

        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d lookups (%0d hits) and %0d fills (%0d stored), %0d slot aliases",
                 n_lookup, n_hit, n_fill, n_stored, n_alias);
        $display("with random sender gaps, receiver stalls and one full drain mid-run");
        if (fail_count == 0)
        begin
            $display("hashed_direct_mapped_lookup_cache_unit verification clean");
        end
        else
        begin
            $display("hashed_direct_mapped_lookup_cache_unit verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/hdmlc_pkg.sv
rtl/hashed_direct_mapped_lookup_cache_unit.sv
test/cache_result_checker.sv
test/tb_top.sv
